### rtl/time_slice_process_scheduler_unit_macros.svh
// ------------------------------------------------------------------
// time_slice_process_scheduler_unit_macros
// assertion macros for the scheduler
// ------------------------------------------------------------------
`ifndef TIME_SLICE_PROCESS_SCHEDULER_UNIT_MACROS_SVH
`define TIME_SLICE_PROCESS_SCHEDULER_UNIT_MACROS_SVH
// implication checked at every clock edge outside reset
`define TSPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define TSPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### rtl/tsps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------
// tsps_pkg
// shared types and constants of the time-slice scheduler
// ------------------------------------------------------------------
package tsps_pkg;
   localparam int MAX_PROCS_DEF = 16;
   localparam int TICK_W = 64;
   localparam logic [15:0] BUDGET_RESET = 16'd100;

   typedef enum logic [1:0] {
      REQ_SPAWN = 2'd0, REQ_KILL = 2'd1, REQ_PICK = 2'd2, REQ_RETIRE = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_READY = 2'd0, ST_RUNNING = 2'd1, ST_BLOCKED = 2'd2, ST_DEAD = 2'd3
   } slot_state_type;

   typedef enum logic [1:0] {
      RSP_OK = 2'd0, RSP_REFUSED = 2'd1, RSP_IDLE = 2'd2, RSP_FFWD = 2'd3
   } rsp_code_type;

   typedef enum logic [3:0] {
      FSM_IDLE, FSM_KILL_RD, FSM_RET_RD, FSM_SCAN, FSM_MIN, FSM_WAKE_RD,
      FSM_WAKE, FSM_RESP
   } fsm_type;
endpackage
`default_nettype wire

### rtl/tsps_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------
// tsps_req_if / tsps_rsp_if / tsps_csr_if
// valid-ready channels of the scheduler
// ------------------------------------------------------------------
interface tsps_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [4:0]  target_pid;
   logic [7:0]  step_cost;
   logic        did_halt;
   logic        did_fault;
   logic        sleep_request;
   logic [31:0] sleep_ticks;
   modport source (output valid, req_type, target_pid, step_cost, did_halt, did_fault,
                   sleep_request, sleep_ticks, input ready);
   modport sink (input valid, req_type, target_pid, step_cost, did_halt, did_fault,
                 sleep_request, sleep_ticks, output ready);
endinterface

interface tsps_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [4:0]  chosen_pid;
   logic [63:0] tick_now;
   modport source (output valid, status, chosen_pid, tick_now, input ready);
   modport sink (input valid, status, chosen_pid, tick_now, output ready);
endinterface

interface tsps_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/time_slice_process_scheduler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------
// time_slice_process_scheduler_unit
// round-robin time-slice scheduler over a memory of process slots
// ------------------------------------------------------------------
// One transaction in, one transaction out. Spawn needs no memory read; kill and
// retire do one memory read, then the update. Pick walks the slot memory
// one entry per cycle from the current slot until it finds a runnable slot;
// with none, a second walk finds the earliest wake tick and a third readies
// due slots. The single read port of the slot memory sets this pace.
// A finished response waits in an output register; the next request is
// taken once it has been handed off.
`include "time_slice_process_scheduler_unit_macros.svh"
module time_slice_process_scheduler_unit #(
   parameter int MAX_PROCS = tsps_pkg::MAX_PROCS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   tsps_req_if.sink   req,
   tsps_rsp_if.source rsp,
   tsps_csr_if.sink   csr
);
   localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CW = $clog2(MAX_PROCS + 1);
   localparam int TW = tsps_pkg::TICK_W;

   // slot memory: state and wake tick, one read and one write port
   logic [1:0]    st_mem [MAX_PROCS];
   logic [TW-1:0] wk_mem [MAX_PROCS];
   logic [IW-1:0] rd_addr;
   logic          rd_en;
   logic [1:0]    rd_st_ff;
   logic [TW-1:0] rd_wk_ff;
   logic          wr_en, wr_wk;
   logic [IW-1:0] wr_addr;
   logic [1:0]    wr_st;
   logic [TW-1:0] wr_wk_data;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_st_ff <= st_mem[rd_addr];
         rd_wk_ff <= wk_mem[rd_addr];
      end
      if (wr_en) begin
         st_mem[wr_addr] <= wr_st;
         if (wr_wk) wk_mem[wr_addr] <= wr_wk_data;
      end
   end

   tsps_pkg::fsm_type fsm_ff, fsm_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [16:0]   used_ff, used_in;
   logic [TW-1:0] tick_ff, tick_in;
   logic [15:0]   budget_ff;
   // request capture
   logic [4:0]    rq_pid_ff;
   logic [7:0]    rq_cost_ff;
   logic          rq_end_ff, rq_sleep_ff;
   logic [31:0]   rq_ticks_ff;
   // walk state
   logic [IW-1:0] idx_ff, idx_in;   // slot being read
   logic [CW-1:0] left_ff, left_in; // reads still to check
   logic          found_ff, found_in;
   logic [TW-1:0] early_ff, early_in;
   // response
   logic          rv_ff, rv_in;
   logic [1:0]    rs_ff, rs_in;
   logic [4:0]    rp_ff, rp_in;

   logic          req_take;
   logic [8:0]    cost;
   logic [16:0]   used_sum;
   logic [IW-1:0] idx_next, slot_wrap;

   assign req.ready = (fsm_ff == tsps_pkg::FSM_IDLE) && !rv_ff;
   assign req_take  = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign rsp.valid = rv_ff;
   assign rsp.status = rs_ff;
   assign rsp.chosen_pid = rp_ff;
   assign rsp.tick_now = tick_ff;

   assign cost = (rq_cost_ff == 8'd0) ? 9'd1 : {1'b0, rq_cost_ff};
   assign used_sum = used_ff + {8'd0, cost};

   // next slot in the active ring of count_ff entries
   always_comb begin
      if ({1'b0, idx_ff} + 1'b1 >= (IW+1)'(count_ff)) idx_next = '0;
      else idx_next = idx_ff + 1'b1;
      if ({1'b0, cur_ff} + 1'b1 >= (IW+1)'(count_ff)) slot_wrap = '0;
      else slot_wrap = cur_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= tsps_pkg::FSM_IDLE;
         count_ff <= '0;
         cur_ff <= '0;
         used_ff <= '0;
         tick_ff <= '0;
         budget_ff <= tsps_pkg::BUDGET_RESET;
         rv_ff <= 1'b0;
      end else begin
         fsm_ff <= fsm_in;
         count_ff <= count_in;
         cur_ff <= cur_in;
         used_ff <= used_in;
         tick_ff <= tick_in;
         rv_ff <= rv_in;
         if (csr.valid) budget_ff <= csr.data;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      left_ff <= left_in;
      found_ff <= found_in;
      early_ff <= early_in;
      rs_ff <= rs_in;
      rp_ff <= rp_in;
      if (req_take) begin
         rq_pid_ff <= req.target_pid;
         rq_cost_ff <= req.step_cost;
         rq_end_ff <= req.did_halt | req.did_fault;
         rq_sleep_ff <= req.sleep_request;
         rq_ticks_ff <= req.sleep_ticks;
      end
   end

   always_comb begin
      fsm_in = fsm_ff;
      count_in = count_ff; cur_in = cur_ff; used_in = used_ff; tick_in = tick_ff;
      idx_in = idx_ff; left_in = left_ff; found_in = found_ff; early_in = early_ff;
      rv_in = rv_ff; rs_in = rs_ff; rp_in = rp_ff;
      rd_en = 1'b0; rd_addr = idx_ff;
      wr_en = 1'b0; wr_wk = 1'b0; wr_addr = idx_ff; wr_st = tsps_pkg::ST_READY;
      wr_wk_data = '0;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      case (fsm_ff)
         tsps_pkg::FSM_IDLE: begin
            if (req_take) begin
               case (tsps_pkg::req_code_type'(req.req_type))
                  tsps_pkg::REQ_SPAWN: begin
                     rp_in = '0;
                     rs_in = tsps_pkg::RSP_REFUSED;
                     if (count_ff < CW'(MAX_PROCS)) begin
                        wr_en = 1'b1; wr_wk = 1'b1;
                        wr_addr = count_ff[IW-1:0];
                        count_in = count_ff + 1'b1;
                        rs_in = tsps_pkg::RSP_OK;
                        rp_in = 5'(count_ff + 1'b1);
                     end
                     fsm_in = tsps_pkg::FSM_RESP;
                  end
                  tsps_pkg::REQ_KILL: begin
                     rd_en = 1'b1;
                     rd_addr = IW'(req.target_pid - 5'd1);
                     idx_in = IW'(req.target_pid - 5'd1);
                     fsm_in = tsps_pkg::FSM_KILL_RD;
                  end
                  tsps_pkg::REQ_PICK: begin
                     rs_in = tsps_pkg::RSP_IDLE; rp_in = '0;
                     if (count_ff == '0) begin
                        tick_in = tick_ff + 1'b1;
                        fsm_in = tsps_pkg::FSM_RESP;
                     end else begin
                        rd_en = 1'b1; rd_addr = cur_ff;
                        idx_in = cur_ff; left_in = count_ff;
                        fsm_in = tsps_pkg::FSM_SCAN;
                     end
                  end
                  default: begin
                     rd_en = 1'b1; rd_addr = cur_ff; idx_in = cur_ff;
                     fsm_in = tsps_pkg::FSM_RET_RD;
                  end
               endcase
            end
         end
         tsps_pkg::FSM_KILL_RD: begin
            fsm_in = tsps_pkg::FSM_RESP;
            if (rq_pid_ff == '0 || 32'(rq_pid_ff) > 32'(count_ff)
                || rd_st_ff == tsps_pkg::ST_DEAD) begin
               rs_in = tsps_pkg::RSP_REFUSED; rp_in = '0;
            end else begin
               wr_en = 1'b1; wr_st = tsps_pkg::ST_DEAD;
               rs_in = tsps_pkg::RSP_OK; rp_in = rq_pid_ff;
            end
         end
         tsps_pkg::FSM_RET_RD: begin
            fsm_in = tsps_pkg::FSM_RESP;
            if (count_ff == '0 || rd_st_ff != tsps_pkg::ST_RUNNING) begin
               rs_in = tsps_pkg::RSP_REFUSED; rp_in = '0;
            end else begin
               rs_in = tsps_pkg::RSP_OK; rp_in = 5'({1'b0, cur_ff} + 1'b1);
               wr_en = 1'b1; wr_addr = cur_ff;
               wr_st = tsps_pkg::ST_RUNNING;
               tick_in = tick_ff + {55'd0, cost};
               used_in = used_sum;
               if (rq_sleep_ff) begin
                  wr_st = tsps_pkg::ST_BLOCKED; wr_wk = 1'b1;
                  wr_wk_data = tick_ff + {32'd0, rq_ticks_ff};
               end
               if (rq_end_ff) wr_st = tsps_pkg::ST_DEAD;
               if (rq_end_ff || used_sum >= {1'b0, budget_ff}) begin
                  if (wr_st == tsps_pkg::ST_RUNNING) wr_st = tsps_pkg::ST_READY;
                  cur_in = slot_wrap;
                  used_in = '0;
               end
            end
         end
         tsps_pkg::FSM_SCAN: begin
            // rd data holds slot idx_ff
            if (rd_st_ff == tsps_pkg::ST_READY || rd_st_ff == tsps_pkg::ST_RUNNING) begin
               wr_en = 1'b1; wr_st = tsps_pkg::ST_RUNNING;
               cur_in = idx_ff;
               rs_in = tsps_pkg::RSP_OK; rp_in = 5'({1'b0, idx_ff} + 1'b1);
               fsm_in = tsps_pkg::FSM_RESP;
            end else if (left_ff == CW'(1)) begin
               rd_en = 1'b1; rd_addr = '0; idx_in = '0;
               left_in = count_ff; found_in = 1'b0;
               fsm_in = tsps_pkg::FSM_MIN;
            end else begin
               rd_en = 1'b1; rd_addr = idx_next; idx_in = idx_next;
               left_in = left_ff - 1'b1;
            end
         end
         tsps_pkg::FSM_MIN: begin
            if (rd_st_ff == tsps_pkg::ST_BLOCKED && (!found_ff || rd_wk_ff < early_ff)) begin
               early_in = rd_wk_ff; found_in = 1'b1;
            end
            if (left_ff == CW'(1)) begin
               fsm_in = tsps_pkg::FSM_WAKE_RD;
            end else begin
               rd_en = 1'b1; rd_addr = idx_next; idx_in = idx_next;
               left_in = left_ff - 1'b1;
            end
         end
         tsps_pkg::FSM_WAKE_RD: begin
            if (!found_ff) begin
               tick_in = tick_ff + 1'b1;
               fsm_in = tsps_pkg::FSM_RESP;
            end else begin
               if (early_ff > tick_ff) tick_in = early_ff;
               rs_in = tsps_pkg::RSP_FFWD;
               rd_en = 1'b1; rd_addr = '0; idx_in = '0; left_in = count_ff;
               fsm_in = tsps_pkg::FSM_WAKE;
            end
         end
         tsps_pkg::FSM_WAKE: begin
            if (rd_st_ff == tsps_pkg::ST_BLOCKED && rd_wk_ff <= tick_ff) begin
               wr_en = 1'b1; wr_st = tsps_pkg::ST_READY;
            end
            if (left_ff == CW'(1)) begin
               fsm_in = tsps_pkg::FSM_RESP;
            end else begin
               rd_en = 1'b1; rd_addr = idx_next; idx_in = idx_next;
               left_in = left_ff - 1'b1;
            end
         end
         tsps_pkg::FSM_RESP: begin
            rv_in = 1'b1;
            fsm_in = tsps_pkg::FSM_IDLE;
         end
         default: fsm_in = tsps_pkg::FSM_IDLE;
      endcase
   end

   `TSPS_ASSERT_IMPL(a_ready_only_idle, clock, reset, req.ready, fsm_ff == tsps_pkg::FSM_IDLE)
   `TSPS_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff <= CW'(MAX_PROCS))
   `TSPS_ASSERT_NEXT(a_take_no_rsp, clock, reset, req_take, !rv_ff)
   `TSPS_ASSERT_IMPL(a_rsp_after_resp, clock, reset, $rose(rv_ff),
                     $past(fsm_ff) == tsps_pkg::FSM_RESP)
endmodule
`default_nettype wire

### verif/tsps_tb_if.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------
// tsps testbench channel notes
// the channel interfaces come from the rtl tree; this file only adds
// a small bundle of stimulus fields and an expected-response record used by the testbench top
// ------------------------------------------------------------------
package tsps_tb_pkg;
   typedef struct {
      tsps_pkg::req_code_type kind;
      logic [4:0]   pid;
      logic [7:0]   cost;
      logic         halt;
      logic         fault;
      logic         sleep;
      logic [31:0]  ticks;
      logic         is_cfg;
      logic [15:0]  budget;
   } sched_op_type;

   typedef struct {
      logic [1:0]  status;
      logic [4:0]  pid;
      logic [63:0] tick;
   } sched_rsp_type;
endpackage

### verif/tb_time_slice_process_scheduler_unit.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------
// tb_time_slice_process_scheduler_unit
// self-checking test of the round-robin time-slice scheduler
// ------------------------------------------------------------------
// a queue of operations drives the request channel; a behavioral
// scheduler model predicts each response, which the monitor compares
// field by field. budget writes are issued only when the unit is idle.
module tb_time_slice_process_scheduler_unit;
   localparam int NPROC = tsps_pkg::MAX_PROCS_DEF;

   logic clock = 0;
   logic reset = 1;

   tsps_req_if req ();
   tsps_rsp_if rsp ();
   tsps_csr_if csr ();

   time_slice_process_scheduler_unit #(.MAX_PROCS(NPROC)) dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // scheduler model state
   tsps_pkg::slot_state_type mdl_state [NPROC];
   logic [63:0]    mdl_wake [NPROC];
   int unsigned    mdl_count, mdl_cur, mdl_used;
   logic [63:0]    mdl_tick;
   logic [15:0]    mdl_budget;

   tsps_tb_pkg::sched_op_type  pending_ops [$];
   tsps_tb_pkg::sched_rsp_type expected_rsps [$];
   int         mismatches = 0;
   bit         quiet_drive = 0;  // long stretch with no idling
   bit         hold_rsp = 0;     // receiver hold-off for back pressure

   // predicted response for one operation, updates model state
   function automatic tsps_tb_pkg::sched_rsp_type schedule_step(tsps_tb_pkg::sched_op_type op);
      tsps_tb_pkg::sched_rsp_type r;
      int unsigned i, idx, n, cur, cost;
      bit found;
      logic [63:0] earliest;
      n = mdl_count;
      r.status = tsps_pkg::RSP_REFUSED; r.pid = 0;
      found = 0; earliest = 0;
      case (op.kind)
         tsps_pkg::REQ_SPAWN: begin
            if (n < NPROC) begin
               mdl_state[n] = tsps_pkg::ST_READY; mdl_wake[n] = 0; mdl_count = n + 1;
               r.status = tsps_pkg::RSP_OK; r.pid = n + 1;
            end
         end
         tsps_pkg::REQ_KILL: begin
            if (op.pid != 0 && op.pid <= n && mdl_state[op.pid-1] != tsps_pkg::ST_DEAD) begin
               mdl_state[op.pid-1] = tsps_pkg::ST_DEAD;
               r.status = tsps_pkg::RSP_OK; r.pid = op.pid;
            end
         end
         tsps_pkg::REQ_PICK: begin
            if (n == 0) begin
               mdl_tick++; r.status = tsps_pkg::RSP_IDLE;
            end else begin
               for (i = 0; i < n && !found; i++) begin
                  idx = (mdl_cur + i) % n;
                  if (mdl_state[idx] == tsps_pkg::ST_READY ||
                      mdl_state[idx] == tsps_pkg::ST_RUNNING) begin
                     mdl_state[idx] = tsps_pkg::ST_RUNNING; mdl_cur = idx;
                     r.status = tsps_pkg::RSP_OK; r.pid = idx + 1; found = 1;
                  end
               end
               if (!found) begin
                  for (i = 0; i < n; i++)
                     if (mdl_state[i] == tsps_pkg::ST_BLOCKED &&
                         (!found || mdl_wake[i] < earliest)) begin
                        earliest = mdl_wake[i]; found = 1;
                     end
                  if (!found) begin
                     mdl_tick++; r.status = tsps_pkg::RSP_IDLE;
                  end else begin
                     if (earliest > mdl_tick) mdl_tick = earliest;
                     for (i = 0; i < n; i++)
                        if (mdl_state[i] == tsps_pkg::ST_BLOCKED && mdl_wake[i] <= mdl_tick)
                           mdl_state[i] = tsps_pkg::ST_READY;
                     r.status = tsps_pkg::RSP_FFWD;
                  end
               end
            end
         end
         default: begin
            if (n != 0 && mdl_cur < n && mdl_state[mdl_cur] == tsps_pkg::ST_RUNNING) begin
               cur = mdl_cur;
               cost = (op.cost == 0) ? 1 : op.cost;
               if (op.sleep) begin
                  mdl_state[cur] = tsps_pkg::ST_BLOCKED;
                  mdl_wake[cur] = mdl_tick + 64'(op.ticks);
               end
               mdl_tick += cost;
               mdl_used += cost;
               if (op.halt || op.fault) begin
                  mdl_state[cur] = tsps_pkg::ST_DEAD; mdl_used = mdl_budget;
               end
               if (mdl_used >= mdl_budget) begin
                  if (mdl_state[cur] == tsps_pkg::ST_RUNNING) mdl_state[cur] = tsps_pkg::ST_READY;
                  mdl_cur = (cur + 1) % n; mdl_used = 0;
               end
               mdl_used &= 32'h1FFFF;
               r.status = tsps_pkg::RSP_OK; r.pid = cur + 1;
            end
         end
      endcase
      r.tick = mdl_tick;
      return r;
   endfunction

   // request / csr driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 0; csr.valid <= 0;
      end else begin
         if (csr.valid && csr.ready) csr.valid <= 0;
         else if (req.valid && !req.ready) begin
            // hold current transaction
         end else if (!csr.valid) begin
            if (pending_ops.size() == 0) begin
               req.valid <= 0;
            end else if (pending_ops[0].is_cfg) begin
               // budget writes wait until every response has come back
               req.valid <= 0;
               if (!(req.valid) && expected_rsps.size() == 0) begin
                  tsps_tb_pkg::sched_op_type c;
                  c = pending_ops.pop_front();
                  mdl_budget = c.budget;
                  csr.data <= c.budget; csr.valid <= 1;
               end
            end else if (!quiet_drive && $urandom_range(99) < 12) begin
               req.valid <= 0;
            end else begin
               tsps_tb_pkg::sched_op_type op;
               tsps_tb_pkg::sched_rsp_type p;
               op = pending_ops.pop_front();
               req.req_type <= op.kind; req.target_pid <= op.pid;
               req.step_cost <= op.cost; req.did_halt <= op.halt;
               req.did_fault <= op.fault; req.sleep_request <= op.sleep;
               req.sleep_ticks <= op.ticks;
               req.valid <= 1;
               p = schedule_step(op);
               expected_rsps.insert(expected_rsps.size(), p);
            end
         end
      end
   end

   // response monitor with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response transaction: st=%0d pid=%0d tick=%0h",
                           rsp.status, rsp.chosen_pid, rsp.tick_now);
            end else begin
               tsps_tb_pkg::sched_rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp.status !== e.status || rsp.chosen_pid !== e.pid ||
                   rsp.tick_now !== e.tick) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp st=%0d pid=%0d tick=%0h got st=%0d pid=%0d tick=%0h",
                              e.status, e.pid, e.tick, rsp.status, rsp.chosen_pid,
                              rsp.tick_now);
               end
            end
         end
         rsp.ready <= !hold_rsp && (quiet_drive || $urandom_range(99) >= 12);
      end
   end

   function automatic tsps_tb_pkg::sched_op_type mk(tsps_pkg::req_code_type k);
      tsps_tb_pkg::sched_op_type o;
      o.kind = k; o.pid = 0; o.cost = 1; o.halt = 0; o.fault = 0; o.sleep = 0;
      o.ticks = 0; o.is_cfg = 0; o.budget = 0;
      return o;
   endfunction

   task automatic queue_op(tsps_tb_pkg::sched_op_type o);
      pending_ops.insert(pending_ops.size(), o);
   endtask

   task automatic push_budget(logic [15:0] b);
      tsps_tb_pkg::sched_op_type o;
      o = mk(tsps_pkg::REQ_SPAWN); o.is_cfg = 1; o.budget = b;
      queue_op(o);
   endtask

   // random operation, weighted toward a lively schedule
   function automatic tsps_tb_pkg::sched_op_type rand_op();
      tsps_tb_pkg::sched_op_type o;
      int w;
      w = $urandom_range(99);
      if (w < 8) o = mk(tsps_pkg::REQ_SPAWN);
      else if (w < 14) o = mk(tsps_pkg::REQ_KILL);
      else if (w < 45) o = mk(tsps_pkg::REQ_PICK);
      else o = mk(tsps_pkg::REQ_RETIRE);
      o.pid = $urandom_range(31);
      if ($urandom_range(3) != 0) o.pid = $urandom_range(16);
      o.cost = $urandom_range(255);
      o.halt = ($urandom_range(99) < 4);
      o.fault = ($urandom_range(99) < 4);
      o.sleep = ($urandom_range(99) < 15);
      o.ticks = ($urandom_range(3) == 0) ? $urandom : $urandom_range(600);
      return o;
   endfunction

   initial begin
      tsps_tb_pkg::sched_op_type o;
      req.valid = 0; req.req_type = tsps_pkg::REQ_SPAWN; req.target_pid = 0;
      req.step_cost = 0;
      req.did_halt = 0; req.did_fault = 0; req.sleep_request = 0; req.sleep_ticks = 0;
      csr.valid = 0; csr.data = 0; rsp.ready = 0;
      mdl_count = 0; mdl_cur = 0; mdl_used = 0; mdl_tick = 0;
      mdl_budget = tsps_pkg::BUDGET_RESET;
      foreach (mdl_state[i]) begin
         mdl_state[i] = tsps_pkg::ST_READY; mdl_wake[i] = 0;
      end

      // directed: empty table cases, then fill, kill edge pids, sleep/ffwd
      queue_op(mk(tsps_pkg::REQ_PICK));
      queue_op(mk(tsps_pkg::REQ_RETIRE));
      o = mk(tsps_pkg::REQ_KILL); o.pid = 0; queue_op(o);
      push_budget(16'd1);
      for (int i = 0; i < 17; i++) queue_op(mk(tsps_pkg::REQ_SPAWN));
      o = mk(tsps_pkg::REQ_KILL); o.pid = 16; queue_op(o);
      o = mk(tsps_pkg::REQ_KILL); o.pid = 16; queue_op(o);
      o = mk(tsps_pkg::REQ_KILL); o.pid = 31; queue_op(o);
      queue_op(mk(tsps_pkg::REQ_PICK));
      o = mk(tsps_pkg::REQ_RETIRE); o.cost = 0; o.sleep = 1; o.ticks = 32'hFFFF_FFFF;
      queue_op(o);
      queue_op(mk(tsps_pkg::REQ_PICK));
      o = mk(tsps_pkg::REQ_RETIRE); o.cost = 255; o.sleep = 1; o.halt = 1; o.ticks = 5;
      queue_op(o);
      queue_op(mk(tsps_pkg::REQ_PICK));
      o = mk(tsps_pkg::REQ_RETIRE); o.fault = 1; queue_op(o);
      push_budget(16'hFFFF);

      // random phases with varied budgets
      for (int ph = 0; ph < 7; ph++) begin
         for (int k = 0; k < 100; k++) queue_op(rand_op());
         case (ph)
            0: push_budget(16'd0);
            1: push_budget(16'd300);
            2: push_budget(16'd1);
            default: push_budget(16'($urandom_range(1, 1000)));
         endcase
      end

      repeat (6) @(posedge clock);
      reset <= 0;

      while (pending_ops.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("time_slice_process_scheduler_unit regression: pass");
      else
         $display("time_slice_process_scheduler_unit regression: fail");
      $finish;
   end

   // stretch with no idling or stalls, then back pressure while the sender keeps offering
   initial begin
      repeat (6) @(posedge clock);
      repeat (300) @(posedge clock);
      quiet_drive = 1;
      repeat (500) @(posedge clock);
      quiet_drive = 0;
      hold_rsp = 1;
      repeat (200) @(posedge clock);
      hold_rsp = 0;
   end

   initial begin
      #5ms;
      $display("time_slice_process_scheduler_unit regression: fail");
      $finish;
   end
endmodule
